/* rtl/multiplexed_display_capture_top_macros.svh */
// assertion macros for the display capture rtl
// expects clk and rst_n in scope at the point of use

`ifndef MULTIPLEXED_DISPLAY_CAPTURE_TOP_MACROS_SVH
`define MULTIPLEXED_DISPLAY_CAPTURE_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define MDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mdc_pkg.sv */
// shared types, constants and decode functions for the display capture block
// no dependencies
`timescale 1ns / 1ps

package mdc_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int CODE_W     = 4;
    localparam int SEL_W      = 8;
    localparam int SEG_W      = 7;
    localparam int CHAR_W     = 7;
    localparam int LIMIT_W    = 14;
    localparam int IDX_W      = 3;
    localparam int POS_W      = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd10000;
    localparam logic [CODE_W-1:0]  BLANK_CODE  = 4'd15;
    localparam logic [CODE_W-1:0]  NUM_NUMERALS = 4'd10;
    localparam logic [IDX_W-1:0]   LAST_DIGIT  = 3'd7;
    localparam logic [POS_W-1:0]   POS_LAST    = 4'd12;
    localparam logic [SEL_W-1:0]   FIRST_SEL   = 8'h80;

    localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 7'h20;
    localparam logic [CHAR_W-1:0] CH_PERIOD = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 7'h2C;
    localparam logic [CHAR_W-1:0] CH_LF     = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;

    // active-low segment patterns, a..g in bits 6..0, numerals 0..9
    localparam logic [SEG_W-1:0] NUMERAL_PATTERN [10] = '{
        7'h01, 7'h4F, 7'h12, 7'h06, 7'h4C, 7'h24, 7'h20, 7'h0F, 7'h00, 7'h04
    };

    typedef logic [NUM_DIGITS-1:0][CODE_W-1:0] line_t;

    typedef struct packed {
        logic  valid;
        line_t line;
    } line_xfer_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    function automatic logic [CODE_W-1:0] seg_decode(input logic [SEG_W-1:0] seg);
        logic [CODE_W-1:0] code;
        code = BLANK_CODE;
        for (int k = 0; k < 10; k++) begin
            if (seg == NUMERAL_PATTERN[k]) begin
                code = CODE_W'(k);
            end
        end
        return code;
    endfunction

    function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        if (code < NUM_NUMERALS) begin
            ch = CH_ZERO + {{(CHAR_W-CODE_W){1'b0}}, code};
        end else begin
            ch = CH_SPACE;
        end
        return ch;
    endfunction

    // text layout: dd.dd,ddd.d lf cr
    function automatic logic [CHAR_W-1:0] char_at(input line_t line,
                                                  input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            4'd0:    ch = code_char(line[0]);
            4'd1:    ch = code_char(line[1]);
            4'd2:    ch = CH_PERIOD;
            4'd3:    ch = code_char(line[2]);
            4'd4:    ch = code_char(line[3]);
            4'd5:    ch = CH_COMMA;
            4'd6:    ch = code_char(line[4]);
            4'd7:    ch = code_char(line[5]);
            4'd8:    ch = code_char(line[6]);
            4'd9:    ch = CH_PERIOD;
            4'd10:   ch = code_char(line[7]);
            4'd11:   ch = CH_LF;
            4'd12:   ch = CH_CR;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/mdc_front.sv */
// front end: takes display snapshots, matches digits, builds one line record
// depends on mdc_pkg
`timescale 1ns / 1ps

module mdc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mdc_pkg::LIMIT_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mdc_pkg::SEL_W-1:0]       digit_select,
    input  logic [mdc_pkg::SEG_W-1:0]       segment_lines,
    output mdc_pkg::line_xfer_t             push,
    input  logic                            push_ready
);
    import mdc_pkg::*;

    line_t                sample_store_reg;
    logic [IDX_W-1:0]     digit_index_reg;
    logic [LIMIT_W-1:0]   sample_count_reg;
    logic [LIMIT_W-1:0]   sample_limit_reg;

    logic [SEL_W-1:0]     target;
    logic [CODE_W-1:0]    code;
    logic                 match;
    logic [LIMIT_W-1:0]   count_inc;
    logic                 advance;
    logic                 line_done;
    logic                 accept;
    line_t                line_now;

    assign cfg_ready = 1'b1;
    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        target    = FIRST_SEL >> digit_index_reg;
        code      = seg_decode(segment_lines);
        match     = (digit_select == target) && (code != BLANK_CODE);
        count_inc = sample_count_reg + 1'b1;
        advance   = match || (count_inc >= sample_limit_reg);
        line_done = advance && (digit_index_reg == LAST_DIGIT);
        // store contents including this sample's numeral when it matches
        line_now  = sample_store_reg;
        if (match)
        begin
            line_now[digit_index_reg] = code;
        end
        push.valid = accept && line_done;
        push.line  = line_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sample_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_store_reg <= {NUM_DIGITS{BLANK_CODE}};
            digit_index_reg  <= '0;
            sample_count_reg <= '0;
        end
        else if (accept)
        begin
            if (line_done)
            begin
                sample_store_reg <= {NUM_DIGITS{BLANK_CODE}};
            end
            else
            begin
                sample_store_reg <= line_now;
            end
            if (advance)
            begin
                sample_count_reg <= '0;
                digit_index_reg  <= digit_index_reg + 1'b1;
            end
            else
            begin
                sample_count_reg <= count_inc;
            end
        end
    end

endmodule

/* rtl/mdc_line_fifo.sv */
// two-entry queue of line records between front and back
// depends on mdc_pkg
`timescale 1ns / 1ps

module mdc_line_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mdc_pkg::line_xfer_t  wr,
    output logic                 wr_ready,
    output mdc_pkg::line_xfer_t  rd,
    input  logic                 rd_ready
);
    import mdc_pkg::*;

    line_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_wr;
    logic        do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign do_wr    = wr.valid && wr_ready;
    assign rd.valid = (count_reg != 2'd0);
    assign rd.line  = mem_reg[rd_ptr_reg];
    assign do_rd    = rd.valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr.line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/mdc_back.sv */
// back end: turns a line record into thirteen text characters, one per cycle unless the output stalls
// depends on mdc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "multiplexed_display_capture_top_macros.svh"

module mdc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mdc_pkg::line_xfer_t           line_in,
    output logic                          line_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mdc_pkg::CHAR_W-1:0]    out_char,
    output logic                          last
);
    import mdc_pkg::*;

    back_state_t          state_reg;
    back_state_t          state_next;
    line_t                line_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 last_reg;

    logic                 adv;
    logic                 at_end;
    logic                 load;

    assign adv    = !out_valid_reg || out_ready;
    assign at_end = (pos_reg == POS_LAST);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (line_in.valid)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (adv && at_end && !line_in.valid)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // next line may be taken while the cr of the current one goes out
    always_comb
    begin
        case (state_reg)
            BK_IDLE: line_ready = 1'b1;
            BK_EMIT: line_ready = adv && at_end;
            default: line_ready = 1'b0;
        endcase
        load = line_in.valid && line_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                pos_reg <= '0;
            end
            else if ((state_reg == BK_EMIT) && adv && !at_end)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (adv)
            begin
                out_valid_reg <= (state_reg == BK_EMIT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            line_reg <= line_in.line;
        end
        if (adv)
        begin
            out_char_reg <= char_at(line_reg, pos_reg);
            last_reg     <= at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    `MDC_ASSERT_NOW(a_last_is_cr, out_valid_reg && last_reg, out_char_reg == CH_CR, "last without cr")
    `MDC_ASSERT_NOW(a_cr_is_last, out_valid_reg && (out_char_reg == CH_CR), last_reg, "cr without last")
    `MDC_ASSERT_NOW(a_pos_range, state_reg == BK_EMIT, pos_reg <= POS_LAST, "char position out of range")
    `MDC_ASSERT_NEXT(a_load_starts, load, (state_reg == BK_EMIT) && (pos_reg == '0), "line load did not start")

endmodule

/* rtl/multiplexed_display_capture_top.sv */
// a finished line passes the line queue, the back line register and the output register
// throughput: one snapshot and one character per cycle unless stalled, thirteen per line
// input stalls only while two finished lines wait in the two-entry line queue
// reset: asynchronous active-low; store blank, digit 1 sought, sample limit 10000
// depends on mdc_pkg, mdc_front, mdc_line_fifo, mdc_back
`timescale 1ns / 1ps

module multiplexed_display_capture_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mdc_pkg::LIMIT_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mdc_pkg::SEL_W-1:0]       digit_select,
    input  logic [mdc_pkg::SEG_W-1:0]       segment_lines,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mdc_pkg::CHAR_W-1:0]      out_char,
    output logic                            last
);
    import mdc_pkg::*;

    line_xfer_t push;
    logic       push_ready;
    line_xfer_t pop;
    logic       pop_ready;

    mdc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .digit_select  (digit_select),
        .segment_lines (segment_lines),
        .push          (push),
        .push_ready    (push_ready)
    );

    mdc_line_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (push),
        .wr_ready (push_ready),
        .rd       (pop),
        .rd_ready (pop_ready)
    );

    mdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_in    (pop),
        .line_ready (pop_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .last       (last)
    );

endmodule
